/* sv/smpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted min-first priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

	// operation codes carried on s_tuser
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;

	localparam int VALUE_W = 32;
	localparam int OCC_W   = 5;
	localparam int M_DATA_W = 72;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP_RD,
		ST_RESP
	} smpq_state_t;

endpackage
`default_nettype wire

/* sv/smpq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* sv/sorted_min_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded min-first priority queue kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tuser carries the command (insert, remove smallest,
//   status), s_tdata the value to insert. Each accepted item yields exactly
//   one result item on the master channel: smallest, largest, occupancy,
//   empty flag, overflow and underflow flags, all after the operation.
//   The values sit in a circular RAM window starting at a head pointer;
//   smallest and largest are also held in registers.
//   Status, remove on an empty queue, remove of the last value, and insert
//   to an empty/full queue or at either end go from accept straight to the
//   result state. Other removes first pass a RAM read state that fetches
//   the new smallest value. An insert in the middle first passes a scan
//   state that moves each stored value larger than it up by one and then
//   writes it, one RAM entry per cycle through the single write port.
//   One item is worked on at a time; a new item is taken while the last
//   result still waits in the output register. If the receiver stalls, the
//   block holds the finished result and waits before presenting the next.
//   Reset empties the queue at once; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core
	import smpq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // [31:0] value
	input  wire logic [1:0]   s_tuser,   // [1:0] cmd
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] smallest, [63:32] largest, [68:64] occupancy, [69] is_empty,
	// [70] overflow_flag, [71] underflow_flag
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	// physical RAM address of logical position k counted from the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, k};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	smpq_state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d;
	logic signed [VALUE_W-1:0] min_q, min_d, max_q, max_d, val_q, val_d;
	logic ovf_q, ovf_d, unf_q, unf_d;
	logic m_tvalid_q, m_tvalid_d;
	logic [M_DATA_W-1:0] m_tdata_q, m_tdata_d;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

	logic signed [VALUE_W-1:0] in_val, rd_val;
	logic [AW-1:0] cnt_idx, head_m1;
	logic [CW+4:0] occ_ext;
	logic          empty;

	smpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_val  = $signed(s_tdata);
	assign rd_val  = $signed(ram_rdata);
	assign cnt_idx = cnt_q[AW-1:0];
	assign head_m1 = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
	assign empty   = (cnt_q == '0);
	assign occ_ext = {5'b0, cnt_q};

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		min_d      = min_q;
		max_d      = max_q;
		val_d      = val_q;
		ovf_d      = ovf_q;
		unf_d      = unf_q;
		m_tdata_d  = m_tdata_q;
		m_tvalid_d = m_tvalid_q;
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = head_q;
		ram_wdata  = s_tdata;
		ram_raddr  = head_q;

		if (m_tvalid_q && m_tready) begin
			m_tvalid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ovf_d   = 1'b0;
					unf_d   = 1'b0;
					val_d   = in_val;
					state_d = ST_RESP;
					case (s_tuser)
						CMD_INSERT: begin
							if (cnt_q == CNT_FULL) begin
								ovf_d = 1'b1;
							end else if (empty) begin
								ram_we    = 1'b1;
								ram_waddr = head_q;
								min_d     = in_val;
								max_d     = in_val;
								cnt_d     = cnt_q + CW'(1);
							end else if (in_val >= max_q) begin
								// equal values go behind, so this lands at the tail
								ram_we    = 1'b1;
								ram_waddr = phys(head_q, cnt_idx);
								max_d     = in_val;
								cnt_d     = cnt_q + CW'(1);
							end else if (in_val < min_q) begin
								ram_we    = 1'b1;
								ram_waddr = head_m1;
								head_d    = head_m1;
								min_d     = in_val;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								// shift larger entries up from the tail
								ram_raddr = phys(head_q, cnt_idx - AW'(1));
								idx_d     = cnt_idx - AW'(1);
								state_d   = ST_SCAN;
							end
						end
						CMD_REMOVE: begin
							if (empty) begin
								unf_d = 1'b1;
							end else begin
								head_d    = phys(head_q, AW'(1));
								cnt_d     = cnt_q - CW'(1);
								ram_raddr = phys(head_q, AW'(1));
								if (cnt_q != CW'(1)) begin
									state_d = ST_POP_RD;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				// entry 0 is the minimum, not above val, so the scan ends by then
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, idx_q + AW'(1));
				if (rd_val > val_q) begin
					ram_wdata = ram_rdata;
					idx_d     = idx_q - AW'(1);
					ram_raddr = phys(head_q, idx_q - AW'(1));
				end else begin
					ram_wdata = val_q;
					cnt_d     = cnt_q + CW'(1);
					state_d   = ST_RESP;
				end
			end
			ST_POP_RD: begin
				min_d   = rd_val;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = {unf_q, ovf_q, empty, occ_ext[OCC_W-1:0],
						empty ? '0 : max_q, empty ? '0 : min_q};
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			cnt_q      <= cnt_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		min_q     <= min_d;
		max_q     <= max_d;
		val_q     <= val_d;
		ovf_q     <= ovf_d;
		unf_q     <= unf_d;
		m_tdata_q <= m_tdata_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire
